/* hdl/keypad_scan_debounce_top_macros.svh */
// ----------------------------------------------------------------------------
// keypad_scan_debounce_top_macros.svh
// assertion macros used by the keypad debounce checker
// ----------------------------------------------------------------------------
`ifndef KEYPAD_SCAN_DEBOUNCE_TOP_MACROS_SVH
`define KEYPAD_SCAN_DEBOUNCE_TOP_MACROS_SVH

// property checked while reset is released
`define KPD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define KPD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/kpd_pkg.sv */
// ----------------------------------------------------------------------------
// kpd_pkg
// shared types, constants and the keymap of the keypad debouncer
// ----------------------------------------------------------------------------
package kpd_pkg;

    // keypad geometry
    localparam int ROW_COUNT = 4;
    localparam int COL_COUNT = 3;
    localparam int LINE_BITS = 3;
    localparam int SCAN_COLS = (COL_COUNT < LINE_BITS) ? COL_COUNT : LINE_BITS;
    localparam int MAP_SIZE  = 12;

    // field widths
    localparam int ROW_W   = 3;
    localparam int LINES_W = 3;
    localparam int TIME_W  = 32;
    localparam int DEB_W   = 16;
    localparam int KEY_W   = 8;
    localparam int COL_W   = 2;
    localparam int IDX_W   = 6;
    localparam int MAP_W   = 4;

    // stream payload widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd30;
    localparam logic [KEY_W-1:0] NO_KEY         = 8'h00;

    // row-major keymap: 1 2 3 / 4 5 6 / 7 8 9 / * 0 #
    localparam logic [KEY_W-1:0] KEY_TABLE [MAP_SIZE] = '{
        8'h31, 8'h32, 8'h33,
        8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39,
        8'h2A, 8'h30, 8'h23
    };

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_PRESSED  = 2'd2,
        PH_RELEASED = 2'd3
    } phase_t;

    // decoded row sample
    typedef struct packed {
        logic              row_ok;
        logic [KEY_W-1:0]  key;
    } sample_t;

    // one result item
    typedef struct packed {
        logic              key_valid;
        logic [KEY_W-1:0]  key_char;
    } result_t;

endpackage

/* hdl/kpd_key_decode.sv */
// ----------------------------------------------------------------------------
// kpd_key_decode
// checks the driven row and maps the lowest low column to its ascii key
// ----------------------------------------------------------------------------
module kpd_key_decode (
    input  logic [kpd_pkg::ROW_W-1:0]   row_number,
    input  logic [kpd_pkg::LINES_W-1:0] column_lines,
    output kpd_pkg::sample_t            sample
);
    import kpd_pkg::*;

    logic             found;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row_m1;
    logic [IDX_W-1:0] idx;

    // priority search, lowest column wins
    always_comb begin
        found = 1'b0;
        col   = '0;
        for (int c = SCAN_COLS - 1; c >= 0; c--) begin
            if (!column_lines[c]) begin
                found = 1'b1;
                col   = COL_W'(c);
            end
        end
    end

    // keymap index and lookup
    assign row_m1 = row_number - 3'd1;
    assign idx    = IDX_W'(row_m1) * IDX_W'(COL_COUNT) + IDX_W'(col);

    always_comb begin
        sample.row_ok = (row_number != '0) && (row_number <= ROW_W'(ROW_COUNT));
        if (found && (idx < IDX_W'(MAP_SIZE))) begin
            sample.key = KEY_TABLE[idx[MAP_W-1:0]];
        end else begin
            sample.key = NO_KEY;
        end
    end

endmodule

/* hdl/kpd_fsm.sv */
// ----------------------------------------------------------------------------
// kpd_fsm
// press / release state machine with elapsed-time debounce
// ----------------------------------------------------------------------------
module kpd_fsm (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [kpd_pkg::ROW_W-1:0]   row_number,
    input  kpd_pkg::sample_t            sample,
    input  logic [kpd_pkg::TIME_W-1:0]  now_ms,
    input  logic [kpd_pkg::DEB_W-1:0]   debounce_ms,
    output kpd_pkg::result_t            result
);
    import kpd_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [KEY_W-1:0]  held_key_reg, held_key_next;
    logic [ROW_W-1:0]  held_row_reg, held_row_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic [TIME_W-1:0] elapsed;
    logic              timed_out;
    logic              same_row;
    logic              no_key;

    assign elapsed   = now_ms - start_reg;
    assign timed_out = elapsed > TIME_W'(debounce_ms);
    assign same_row  = row_number == held_row_reg;
    assign no_key    = sample.key == NO_KEY;

    // next state
    always_comb begin
        phase_next = phase_reg;
        if (sample.row_ok) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (!no_key) phase_next = PH_DEBOUNCE;
                end
                PH_DEBOUNCE: begin
                    if (sample.key == held_key_reg && timed_out) begin
                        phase_next = PH_PRESSED;
                    end else if (same_row && no_key) begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_PRESSED: begin
                    if (same_row && no_key) phase_next = PH_RELEASED;
                end
                PH_RELEASED: begin
                    if (same_row && timed_out) phase_next = PH_IDLE;
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // held key, timer and result
    always_comb begin
        held_key_next   = held_key_reg;
        held_row_next   = held_row_reg;
        start_next      = start_reg;
        result.key_valid = 1'b0;
        result.key_char  = NO_KEY;
        if (sample.row_ok) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (!no_key) begin
                        held_key_next = sample.key;
                        held_row_next = row_number;
                        start_next    = now_ms;
                    end
                end
                PH_PRESSED: begin
                    if (same_row && no_key) start_next = now_ms;
                end
                PH_RELEASED: begin
                    if (same_row && timed_out) begin
                        result.key_valid = 1'b1;
                        result.key_char  = held_key_reg;
                        held_key_next    = NO_KEY;
                        held_row_next    = '0;
                    end
                end
                default: begin
                    held_key_next = held_key_reg;
                end
            endcase
        end
    end

    // state registers, advance once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            held_key_reg <= NO_KEY;
            held_row_reg <= '0;
            start_reg    <= '0;
        end else if (step) begin
            phase_reg    <= phase_next;
            held_key_reg <= held_key_next;
            held_row_reg <= held_row_next;
            start_reg    <= start_next;
        end
    end

endmodule

/* hdl/keypad_scan_debounce_top.sv */
// a request in the input register moves to the result register once that one is empty or taken
// one request per cycle while the result is not stalled, one result per request
// a stalled result stays in the output register while the input register
// still takes one more request
// reset: synchronous active-low aresetn clears the state machine, both
// stages and sets debounce_ms to 30
// ----------------------------------------------------------------------------
// keypad_scan_debounce_top
// 4x3 matrix keypad debouncer with stream input and output
// ----------------------------------------------------------------------------
module keypad_scan_debounce_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // row_number[2:0], column_lines[5:3], now_ms[37:6], zero pad
    input  logic [kpd_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // key_char[7:0]
    output logic [kpd_pkg::M_TDATA_W-1:0]   m_tdata,
    // key_valid[0]
    output logic                            m_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // debounce_ms[15:0]
    input  logic [kpd_pkg::DEB_W-1:0]       cfg_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready
);
    import kpd_pkg::*;

    logic [DEB_W-1:0]   debounce_reg;
    logic               in_valid_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [LINES_W-1:0] lines_reg;
    logic [TIME_W-1:0]  now_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    logic               advance;
    sample_t            sample;
    result_t            result;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
        end else if (cfg_valid) begin
            debounce_reg <= cfg_data;
        end
    end

    // handshake between the two stages
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            row_reg   <= s_tdata[ROW_W-1:0];
            lines_reg <= s_tdata[ROW_W+LINES_W-1:ROW_W];
            now_reg   <= s_tdata[ROW_W+LINES_W+TIME_W-1:ROW_W+LINES_W];
        end
    end

    kpd_key_decode u_decode (
        .row_number   (row_reg),
        .column_lines (lines_reg),
        .sample       (sample)
    );

    kpd_fsm u_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .row_number  (row_reg),
        .sample      (sample),
        .now_ms      (now_reg),
        .debounce_ms (debounce_reg),
        .result      (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.key_char;
    assign m_tuser  = out_reg.key_valid;

endmodule

/* hdl/kpd_checker.sv */
// ----------------------------------------------------------------------------
// kpd_checker
// port-level checks of the keypad debouncer, bound to the top level
// ----------------------------------------------------------------------------
`include "keypad_scan_debounce_top_macros.svh"

module kpd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [kpd_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                            m_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready
);
    import kpd_pkg::*;

    // no key reported means a zero character
    `KPD_ASSERT(a_idle_char_zero, aclk, aresetn, (m_tvalid && !m_tuser) |-> (m_tdata == NO_KEY), "key_char not zero without key_valid")

    // a reported key is never the empty code
    `KPD_ASSERT(a_key_nonzero, aclk, aresetn, (m_tvalid && m_tuser) |-> (m_tdata != NO_KEY), "key_valid with empty key_char")

    // an empty output stage never blocks the input
    `KPD_ASSERT(a_ready_when_empty, aclk, aresetn, !m_tvalid |-> s_tready, "input stalled while output empty")

    // a stalled result holds
    `KPD_ASSERT(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

    // reset empties the output
    `KPD_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid right after reset")

endmodule

bind keypad_scan_debounce_top kpd_checker u_kpd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
